FILE: rtl/kli_pkg.sv
// ============================================================================
// kli_pkg: shared types and constants for the keyframe linear interpolator
// Item structs, op codes, sequencer states and table geometry.
// ============================================================================
package kli_pkg;

    localparam int DEPTH     = 256;
    localparam int FRAC_BITS = 16;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = AW + 1;
    localparam int TW        = 32;
    localparam int VW        = 48;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_QUERY  = 2'd1,
        OP_REWIND = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         index;
        logic [31:0]        stamp;
        logic signed [15:0] steer_in;
        logic [14:0]        throttle_in;
        logic [14:0]        brake_in;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] steer_out;
        logic [14:0]        throttle_out;
        logic [14:0]        brake_out;
        logic [7:0]         segment;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_CHK_FIRST,
        ST_CHK_LAST,
        ST_FWD,
        ST_BACK,
        ST_RD_SEG,
        ST_SEG_WAIT,
        ST_DIV,
        ST_LERP_MUL,
        ST_LERP_ADD,
        ST_OUT
    } state_t;

    // control from sequencer to divider
    typedef struct packed {
        logic start;
    } div_ctl_t;

endpackage

FILE: rtl/kli_ram.sv
// ============================================================================
// kli_ram: generic single-port-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module kli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/kli_div.sv
// ============================================================================
// kli_div: serial restoring divider for the interpolation fraction
// Computes floor((num << FRAC_BITS) / den), one quotient bit per cycle.
// ============================================================================
module kli_div
    import kli_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  div_ctl_t             ctl,
    input  logic [TW-1:0]        num,
    input  logic [TW-1:0]        den,
    output logic                 done,
    output logic [FRAC_BITS:0]   quot
);

    localparam int NB = FRAC_BITS;
    localparam int CB = $clog2(NB + 1);

    logic [TW:0]        rem_reg, rem_next;
    logic [TW-1:0]      den_reg, den_next;
    logic [FRAC_BITS:0] q_reg, q_next;
    logic [CB-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [TW+1:0]      trial;

    // one restoring step per cycle; num < den so quotient fits FRAC_BITS+1
    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = '0;
        if (ctl.start) begin
            rem_next  = {1'b0, num};
            den_next  = den;
            q_next    = '0;
            cnt_next  = CB'(NB);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {rem_reg, 1'b0} - {2'b00, den_reg};
            if (!trial[TW+1]) begin
                rem_next = trial[TW:0];
                q_next   = {q_reg[FRAC_BITS-1:0], 1'b1};
            end else begin
                rem_next = {rem_reg[TW-1:0], 1'b0};
                q_next   = {q_reg[FRAC_BITS-1:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CB'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    // remainder starts as num (< den), so the top quotient bit is zero and
    // FRAC_BITS steps give the full fraction
    assign done = busy_reg && (cnt_reg == CB'(1));
    assign quot = q_next;

endmodule

FILE: rtl/keyframe_linear_interpolator.sv
// ============================================================================
// keyframe_linear_interpolator: timestamped sample table with linear lookup
// Loads samples, then answers queries by cursor walk, serial divide and lerp.
// ============================================================================
//  channel  | ports              | payload
//  input    | s_valid / s_ready  | s_item  (in_item_t)
//  result   | m_valid / m_ready  | m_item  (out_item_t)
//  config   | cfg_we             | cfg_data (sample_count, 9 bits)
//
// A query or rewind on an empty table goes straight to the result. A rewind, or
// a query at or before the first sample, ends at the first-sample check, one at
// or after the last at the last-sample check. An interior query walks the cursor
// and reads its segment through one read port, then divides (not for a zero gap).
// s_ready is low while an item is at work or a result waits on m_ready.
// Reset clears the cursor, the count and the sequencer; the tables are not
// cleared.
module keyframe_linear_interpolator
    import kli_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [8:0] cfg_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [AW-1:0] raddr;
    logic [TW-1:0] t_rd;
    logic [VW-1:0] v_rd;
    logic [TW-1:0] stamp_reg;
    logic [TW-1:0] t0_reg, t0_next;
    logic [VW-1:0] v0_reg, v0_next, v1_reg, v1_next;
    logic [1:0]    phase_reg, phase_next;
    logic          fwd_reg, fwd_next;
    logic          zero_reg, zero_next;
    logic [FRAC_BITS:0] f_reg, f_next;
    logic signed [16+FRAC_BITS+2:0] p_reg [3];
    out_item_t     out_reg, out_next;
    logic          m_valid_reg;
    logic [CW-1:0] n;
    logic [AW-1:0] last;
    logic          accept;
    logic          load_we;
    div_ctl_t      dctl;
    logic          ddone;
    logic [FRAC_BITS:0] dq;
    logic [TW-1:0] dnum, dden;

    assign n      = (count_reg > CW'(DEPTH)) ? CW'(DEPTH) : count_reg;
    assign last   = AW'(n - 1'b1);
    assign accept = s_valid && s_ready;
    assign load_we = accept && (s_item.op == OP_LOAD);
    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;

    // table memories
    kli_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_time (
        .aclk(aclk), .we(load_we), .waddr(AW'(s_item.index)),
        .wdata(s_item.stamp), .raddr(raddr), .rdata(t_rd)
    );
    kli_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_value (
        .aclk(aclk), .we(load_we), .waddr(AW'(s_item.index)),
        .wdata({1'b0, s_item.brake_in, 1'b0, s_item.throttle_in, s_item.steer_in}),
        .raddr(raddr), .rdata(v_rd)
    );

    assign dnum = stamp_reg - t0_reg;
    assign dden = t_rd - t0_reg;

    kli_div u_div (
        .aclk(aclk), .aresetn(aresetn), .ctl(dctl),
        .num(dnum), .den(dden), .done(ddone), .quot(dq)
    );

    // channel extraction
    function automatic logic signed [16:0] ch(input logic [VW-1:0] p, input int k);
        logic signed [16:0] r;
        r = '0;
        case (k)
            0:       r = {p[15], p[15:0]};
            1:       r = {2'b00, p[30:16]};
            default: r = {2'b00, p[46:32]};
        endcase
        return r;
    endfunction

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_item.op)
                        OP_QUERY:  state_next = (n == '0) ? ST_OUT : ST_RD_FIRST;
                        OP_REWIND: state_next = (n == '0) ? ST_OUT : ST_RD_FIRST;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD_FIRST:  state_next = ST_CHK_FIRST;
            ST_CHK_FIRST: begin
                if (phase_reg == 2'd2) begin
                    state_next = zero_reg ? ST_OUT :
                                 (stamp_reg <= t_rd) ? ST_OUT : ST_CHK_LAST;
                end
            end
            ST_CHK_LAST: begin
                if (phase_reg == 2'd2) begin
                    state_next = (stamp_reg >= t_rd) ? ST_OUT : ST_FWD;
                end
            end
            ST_FWD: begin
                if (phase_reg == 2'd2 && !fwd_reg) begin
                    state_next = ST_BACK;
                end
            end
            ST_BACK: begin
                if (phase_reg == 2'd2 && !fwd_reg) begin
                    state_next = ST_RD_SEG;
                end
            end
            ST_RD_SEG:    state_next = (phase_reg == 2'd3) ? ST_DIV : ST_RD_SEG;
            ST_SEG_WAIT:  state_next = ST_DIV;
            // zero gap: fraction already 0, no divide to wait for
            ST_DIV:       state_next = (ddone || (phase_reg != '0 && zero_reg)) ?
                                       ST_LERP_MUL : ST_DIV;
            ST_LERP_MUL:  state_next = ST_LERP_ADD;
            ST_LERP_ADD:  state_next = ST_OUT;
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and sequencing outputs
    always_comb begin
        cursor_next = cursor_reg;
        phase_next  = phase_reg;
        fwd_next    = fwd_reg;
        zero_next   = zero_reg;
        t0_next     = t0_reg;
        v0_next     = v0_reg;
        v1_next     = v1_reg;
        f_next      = f_reg;
        out_next    = out_reg;
        raddr       = '0;
        dctl.start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                phase_next = '0;
                zero_next  = 1'b0;
                if (accept) begin
                    out_next = '0;
                    out_next.segment = 8'(cursor_reg);
                    if (s_item.op == OP_REWIND) begin
                        cursor_next = '0;
                        out_next.segment = '0;
                        zero_next = 1'b1;
                    end
                end
            end
            ST_RD_FIRST: begin
                raddr = '0;
                phase_next = 2'd1;
            end
            ST_CHK_FIRST: begin
                raddr = '0;
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 2'd2) begin
                    phase_next = '0;
                    if (zero_reg || stamp_reg <= t_rd) begin
                        cursor_next = '0;
                        out_next = {16'(v_rd[15:0]), v_rd[30:16], v_rd[46:32], 8'd0};
                    end
                end
            end
            ST_CHK_LAST: begin
                raddr = last;
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 2'd2) begin
                    phase_next = '0;
                    if (stamp_reg >= t_rd) begin
                        cursor_next = last;
                        out_next = {16'(v_rd[15:0]), v_rd[30:16], v_rd[46:32],
                                    8'(last)};
                    end else if (cursor_reg > AW'(n - 2'd2)) begin
                        cursor_next = AW'(n - 2'd2);
                    end
                    fwd_next = 1'b1;
                end
            end
            ST_FWD: begin
                // step while stamp >= time[cursor+1]
                raddr = cursor_reg + 1'b1;
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 2'd2) begin
                    phase_next = '0;
                    if ((CW'(cursor_reg) + 1'b1 < n) && stamp_reg >= t_rd) begin
                        cursor_next = cursor_reg + 1'b1;
                    end else begin
                        fwd_next = 1'b0;
                    end
                end else if (phase_reg == 2'd3) begin
                    phase_next = '0;
                end
                if (state_next == ST_BACK) fwd_next = 1'b1;
            end
            ST_BACK: begin
                // step while cursor > 0 and stamp < time[cursor]
                raddr = cursor_reg;
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 2'd2) begin
                    phase_next = '0;
                    if (cursor_reg != '0 && stamp_reg < t_rd) begin
                        cursor_next = cursor_reg - 1'b1;
                    end else begin
                        fwd_next = 1'b0;
                        if (cursor_reg > AW'(n - 2'd2)) cursor_next = AW'(n - 2'd2);
                    end
                end
            end
            ST_RD_SEG: begin
                // phase 0: read lower, phase 2: capture lower / read upper
                phase_next = phase_reg + 1'b1;
                raddr = (phase_reg >= 2'd2) ? cursor_reg + 1'b1 : cursor_reg;
                if (phase_reg == 2'd2) begin
                    t0_next = t_rd;
                    v0_next = v_rd;
                end
                if (phase_reg == 2'd3) begin
                    phase_next = '0;
                end
            end
            ST_SEG_WAIT: begin
                raddr = cursor_reg + 1'b1;
            end
            ST_DIV: begin
                raddr = cursor_reg + 1'b1;
                if (phase_reg == '0) begin
                    v1_next = v_rd;
                    phase_next = 2'd1;
                    if (t_rd > t0_reg && stamp_reg >= t0_reg) begin
                        dctl.start = 1'b1;
                        zero_next = 1'b0;
                    end else begin
                        zero_next = 1'b1;
                    end
                end
                if (ddone || (phase_reg == '0 && !dctl.start)) begin
                    f_next = zero_reg || (phase_reg == '0 && !dctl.start) ? '0 :
                             ((dq > (FRAC_BITS+1)'(1 << FRAC_BITS)) ?
                              (FRAC_BITS+1)'(1 << FRAC_BITS) : dq);
                end
            end
            ST_LERP_ADD: begin
                out_next.steer_out    = 16'(ch(v0_reg, 0) + 17'(p_reg[0] >>> FRAC_BITS));
                out_next.throttle_out = 15'(ch(v0_reg, 1) + 17'(p_reg[1] >>> FRAC_BITS));
                out_next.brake_out    = 15'(ch(v0_reg, 2) + 17'(p_reg[2] >>> FRAC_BITS));
                out_next.segment      = 8'(cursor_reg);
            end
            default: begin
            end
        endcase
    end

    // products (v1 - v0) * f, arithmetic shift gives floor
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            p_reg[k] <= (ch(v1_reg, k) - ch(v0_reg, k)) * $signed({1'b0, f_reg});
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
            phase_reg   <= '0;
            fwd_reg     <= 1'b0;
            zero_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            phase_reg  <= phase_next;
            fwd_reg    <= fwd_next;
            zero_reg   <= zero_next;
            if (cfg_we) count_reg <= cfg_data;
            if (state_reg == ST_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) stamp_reg <= s_item.stamp;
        t0_reg  <= t0_next;
        v0_reg  <= v0_next;
        v1_reg  <= v1_next;
        f_reg   <= f_next;
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    // checks
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LERP_MUL) |-> (f_reg <= (FRAC_BITS+1)'(1 << FRAC_BITS)))
        else $error("fraction out of range");
    a_result_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> m_valid) else $error("result lost");

endmodule

FILE: verif/keyframe_linear_interpolator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_tb: self-checking bench for the sample table
// Loads ascending sample tables at several counts, then issues queries,
// rewinds, stray loads and idle ops with bursty input and stalling output.
// Every result is checked against an in-bench interpolation predictor.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_tb;
    import kli_pkg::*;

    localparam int LIMIT_CYCLES = 10000000;
    localparam int DRAIN_CYCLES = 60;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_we  = 1'b0;
    logic [8:0] cfg_data = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    keyframe_linear_interpolator uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // pending stimulus and expected results
    in_item_t  pending_items[$];
    out_item_t expected_lookups[$];
    int        errors       = 0;
    int        items_queued = 0;
    int        results_seen = 0;
    int        cycles       = 0;

    // predictor state
    bit [31:0] time_tab[DEPTH];
    int        steer_tab[DEPTH];
    int        thr_tab[DEPTH];
    int        brk_tab[DEPTH];
    int        cursor_m = 0;
    int        count_m  = 0;

    // stamps as planned by the stimulus side
    bit [31:0] plan_time[DEPTH];

    function automatic out_item_t sample_at(int i);
        out_item_t r;
        r.steer_out    = steer_tab[i][15:0];
        r.throttle_out = thr_tab[i][14:0];
        r.brake_out    = brk_tab[i][14:0];
        r.segment      = cursor_m[7:0];
        return r;
    endfunction

    // v0 + floor((v1 - v0) * f / 2^FRAC_BITS)
    function automatic longint lerp_chan(longint v0, longint v1, longint f);
        longint p;
        p = (v1 - v0) * f;
        return v0 + (p >>> FRAC_BITS);
    endfunction

    // append one expected result item
    function automatic void note_expected(input out_item_t r);
        expected_lookups = {expected_lookups, r};
    endfunction

    task automatic interp_predict(input in_item_t it);
        int          n;
        out_item_t   r;
        bit [31:0]   t0, t1;
        longint      f;
        longint unsigned num;
        n = (count_m > DEPTH) ? DEPTH : count_m;
        r = '0;
        case (op_t'(it.op))
            OP_LOAD: begin
                time_tab[it.index]  = it.stamp;
                steer_tab[it.index] = int'(it.steer_in);
                thr_tab[it.index]   = int'(it.throttle_in);
                brk_tab[it.index]   = int'(it.brake_in);
            end
            OP_REWIND: begin
                cursor_m = 0;
                if (n != 0) r = sample_at(0);
                r.segment = 8'd0;
                note_expected(r);
            end
            OP_QUERY: begin
                if (n == 0) begin
                    r.segment = cursor_m[7:0];
                end else if (it.stamp <= time_tab[0]) begin
                    cursor_m = 0;
                    r = sample_at(0);
                end else if (it.stamp >= time_tab[n-1]) begin
                    cursor_m = n - 1;
                    r = sample_at(n - 1);
                end else begin
                    // pull back a stale cursor, then walk
                    if (cursor_m > n - 2) cursor_m = n - 2;
                    while (cursor_m + 1 < n && it.stamp >= time_tab[cursor_m+1])
                        cursor_m++;
                    while (cursor_m > 0 && it.stamp < time_tab[cursor_m])
                        cursor_m--;
                    if (cursor_m > n - 2) cursor_m = n - 2;
                    t0 = time_tab[cursor_m];
                    t1 = time_tab[cursor_m+1];
                    f = 0;
                    // zero or negative gap keeps fraction 0
                    if (t1 > t0 && it.stamp >= t0) begin
                        num = longint'(it.stamp - t0) << FRAC_BITS;
                        f = longint'(num / longint'(t1 - t0));
                        if (f > (64'sd1 << FRAC_BITS)) f = 64'sd1 << FRAC_BITS;
                    end
                    r.steer_out = 16'(lerp_chan(steer_tab[cursor_m],
                                                steer_tab[cursor_m+1], f));
                    r.throttle_out = 15'(lerp_chan(thr_tab[cursor_m],
                                                   thr_tab[cursor_m+1], f));
                    r.brake_out = 15'(lerp_chan(brk_tab[cursor_m],
                                                brk_tab[cursor_m+1], f));
                    r.segment = cursor_m[7:0];
                end
                note_expected(r);
            end
            default: ;
        endcase
    endtask

    // driver: bursts of items with random gaps
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready) interp_predict(s_item);
            if (s_valid && !s_ready) begin
                // hold item until taken
            end else if (gap_left > 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0) begin
                s_item  <= pending_items.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    int  stall_mode = 0;
    int  hold_left  = 0;
    bit  long_done  = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
            if (hold_left > 0) begin
                m_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!long_done && results_seen >= 200) begin
                m_ready   <= 1'b0;
                hold_left <= 400;
                long_done <= 1'b1;
            end else begin
                case (stall_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    // monitor: compare each result item with the oldest expectation
    always @(posedge aclk) begin
        out_item_t e;
        int        bad;
        bad = 0;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_lookups.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, m_item);
                bad = 1;
            end else begin
                e = expected_lookups.pop_front();
                if (m_item.steer_out !== e.steer_out) begin
                    $display("%0t: steer_out exp %0d got %0d", $time,
                             e.steer_out, m_item.steer_out);
                    bad++;
                end
                if (m_item.throttle_out !== e.throttle_out) begin
                    $display("%0t: throttle_out exp %0d got %0d", $time,
                             e.throttle_out, m_item.throttle_out);
                    bad++;
                end
                if (m_item.brake_out !== e.brake_out) begin
                    $display("%0t: brake_out exp %0d got %0d", $time,
                             e.brake_out, m_item.brake_out);
                    bad++;
                end
                if (m_item.segment !== e.segment) begin
                    $display("%0t: segment exp %0d got %0d", $time,
                             e.segment, m_item.segment);
                    bad++;
                end
            end
            if (bad != 0) errors <= errors + bad;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("keyframe_linear_interpolator verification failed");
            $finish;
        end
    end

    task automatic push_item(input op_t op, input bit [7:0] idx, input bit [31:0] stamp,
                             input bit [15:0] st, input bit [14:0] th,
                             input bit [14:0] br);
        in_item_t it;
        it.op          = op;
        it.index       = idx;
        it.stamp       = stamp;
        it.steer_in    = st;
        it.throttle_in = th;
        it.brake_in    = br;
        if (op == OP_LOAD) plan_time[idx] = stamp;
        pending_items = {pending_items, it};
        items_queued++;
    endtask

    task automatic push_noise_fields(input op_t op, input bit [31:0] stamp);
        push_item(op, 8'($urandom), stamp, 16'($urandom), 15'($urandom), 15'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || expected_lookups.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(input int value);
        @(posedge aclk);
        cfg_we   <= 1'b1;
        cfg_data <= 9'(value);
        count_m  = value;
        @(posedge aclk);
        cfg_we   <= 1'b0;
    endtask

    function automatic bit [31:0] pick_stamp(int n);
        int k;
        longint gap;
        if (n == 0) return $urandom;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return plan_time[k];
            2: return plan_time[k] + 32'($urandom_range(0, 3)) - 32'd1;
            default: begin
                if (k == n - 1) return plan_time[k] + 32'($urandom_range(0, 7));
                gap = longint'(plan_time[k+1]) - longint'(plan_time[k]);
                if (gap <= 0) return plan_time[k];
                return plan_time[k] + 32'($urandom_range(0, 32'(gap)));
            end
        endcase
    endfunction

    // one setting: load an ascending table, then a mix of lookups
    task automatic run_phase(input int cnt, input int nq);
        int     n, i, r;
        longint t, room, step;
        n = (cnt > DEPTH) ? DEPTH : cnt;
        wait_idle();
        write_count(cnt);
        t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5000);
        for (i = 0; i < n; i++) begin
            room = 64'hFFFF_FFFF - t;
            step = room / (n - i + 1);
            if (i == 0 || $urandom_range(0, 7) == 0 || step == 0) step = 0;
            else if ($urandom_range(0, 1)) step = $urandom_range(1, (step < 1000) ? step : 1000);
            else step = $urandom_range(1, 32'(step));
            t = t + step;
            push_item(OP_LOAD, 8'(i), 32'(t), 16'($urandom), 15'($urandom), 15'($urandom));
        end
        for (i = 0; i < nq; i++) begin
            r = $urandom_range(0, 99);
            if (r < 84) push_noise_fields(OP_QUERY, pick_stamp(n));
            else if (r < 91) push_noise_fields(OP_REWIND, $urandom);
            else if (r < 96) push_noise_fields(OP_LOAD, $urandom);
            else push_noise_fields(OP_NONE, $urandom);
        end
    endtask

    initial begin
        int r;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table: zeros, idle op
        write_count(0);
        push_noise_fields(OP_QUERY, 32'h1234_5678);
        push_noise_fields(OP_REWIND, 32'd0);
        push_noise_fields(OP_NONE, 32'hFFFF_FFFF);
        push_noise_fields(OP_QUERY, 32'd0);

        // two samples spanning the full stamp range, extreme values
        wait_idle();
        push_item(OP_LOAD, 8'd0, 32'd0, 16'h8000, 15'd0, 15'h7FFF);
        push_item(OP_LOAD, 8'd1, 32'hFFFF_FFFF, 16'h7FFF, 15'h7FFF, 15'd0);
        push_item(OP_LOAD, 8'd255, 32'hFFFF_FFFF, 16'h8001, 15'h7FFF, 15'h7FFF);
        wait_idle();
        write_count(2);
        push_noise_fields(OP_QUERY, 32'd0);
        push_noise_fields(OP_QUERY, 32'hFFFF_FFFF);
        push_noise_fields(OP_QUERY, 32'h8000_0000);
        push_noise_fields(OP_QUERY, 32'd1);
        push_noise_fields(OP_QUERY, 32'hFFFF_FFFE);
        push_noise_fields(OP_REWIND, 32'd0);
        push_noise_fields(OP_QUERY, 32'h5555_5555);
        // reloaded slot 1 takes the stamp of slot 0, a zero gap
        push_item(OP_LOAD, 8'd1, 32'd0, 16'h0100, 15'd5, 15'd9);
        push_noise_fields(OP_QUERY, 32'hAAAA_AAAA);
        push_noise_fields(OP_NONE, 32'd7);

        // single sample, then a full table, then shrink (stale cursor)
        run_phase(1, 8);
        run_phase(DEPTH, 40);
        run_phase(3, 30);

        while (items_queued < 1600) begin
            r = $urandom_range(0, 19);
            if (r == 0) run_phase(0, 10);
            else if (r == 1) run_phase(1, 20);
            else if (r == 2) run_phase(300, 30);
            else if (r == 3) run_phase(64, 60);
            else run_phase($urandom_range(2, 12), 60);
        end

        wait_idle();
        if (errors == 0 && expected_lookups.size() == 0) begin
            $display("keyframe_linear_interpolator verification clean");
        end else begin
            $display("keyframe_linear_interpolator verification failed");
        end
        $finish;
    end

endmodule
